@@ src/pal_pkg.sv @@
package pal_pkg;

  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POS  = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_ERASE,
    CELL_READ
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

@@ src/pal_cell.sv @@
module pal_cell #(
  parameter int AW  = 7,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  pal_pkg::cell_ctl_t                 ctl,
  input  logic [AW-1:0]                      at,
  input  logic signed [pal_pkg::WORD_W-1:0]  prev_word,
  input  logic signed [pal_pkg::WORD_W-1:0]  next_word,
  output logic signed [pal_pkg::WORD_W-1:0]  word,
  output logic signed [pal_pkg::WORD_W-1:0]  hit_word
);

  localparam logic [AW-1:0] ID = AW'(IDX);

  logic signed [pal_pkg::WORD_W-1:0] word_r;
  logic signed [pal_pkg::WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      pal_pkg::CELL_APPEND: begin
        if (ID == at) word_nxt = ctl.word;
      end
      pal_pkg::CELL_INSERT: begin
        if (ID == at) word_nxt = ctl.word;
        else if (ID > at) word_nxt = prev_word;
      end
      pal_pkg::CELL_ERASE: begin
        if (ID >= at) word_nxt = next_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign hit_word = (ctl.op == pal_pkg::CELL_READ && ID == at) ? word_r : '0;

endmodule

@@ src/positional_array_list.sv @@
// channel | ports                                              | beat taken when
// in      | start, busy, in_kind, in_position, in_word_in      | start && !busy
// out     | out_valid, out_word_out, out_count, out_is_empty,  | out_valid (one cycle)
//         | out_status                                         |
// Every operation, including insert and erase, acts on all cells at once: the row of
// cells shifts all entries in the same edge, and the read gathers from all cells.
// A result appears the cycle after its beat; a beat can be taken every cycle.
// busy is never raised. Reset clears the length; the word store is not cleared.
// The receiver cannot stall, so results are never held.
module positional_array_list #(
  parameter int DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pal_pkg::KIND_W-1:0]          in_kind,
  input  logic [pal_pkg::POS_W-1:0]           in_position,
  input  logic signed [pal_pkg::WORD_W-1:0]   in_word_in,
  output logic                                out_valid,
  output logic signed [pal_pkg::WORD_W-1:0]   out_word_out,
  output logic [pal_pkg::COUNT_W-1:0]         out_count,
  output logic                                out_is_empty,
  output logic [pal_pkg::STATUS_W-1:0]        out_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int PW = pal_pkg::POS_W;
  localparam int CW = pal_pkg::COUNT_W;

  logic [FW-1:0] fill_r, fill_nxt;
  logic          out_valid_r;
  logic signed [pal_pkg::WORD_W-1:0] word_out_r;
  logic [CW-1:0]                     count_r;
  logic                              is_empty_r;
  logic [pal_pkg::STATUS_W-1:0]      status_r, status_nxt;

  pal_pkg::cell_ctl_t ctl;
  logic [AW-1:0]      at;
  logic               accept;
  logic               full;
  logic               pos_ok;
  logic [FW+PW-1:0]   pos_cmp, fill_cmp;
  logic [AW+PW-1:0]   pos_wide;
  logic [FW+CW-1:0]   fill_ext;
  logic [FW-1:0]      fill_dec;

  logic signed [pal_pkg::WORD_W-1:0] cell_word [DEPTH];
  logic signed [pal_pkg::WORD_W-1:0] cell_hit  [DEPTH];
  logic signed [pal_pkg::WORD_W-1:0] gathered;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign full     = (fill_r == FW'(DEPTH));
  assign pos_cmp  = {{FW{1'b0}}, in_position};
  assign fill_cmp = {{PW{1'b0}}, fill_r};
  assign pos_ok   = (pos_cmp < fill_cmp);
  assign pos_wide = {{AW{1'b0}}, in_position};
  assign fill_dec = fill_r - FW'(1);

  always_comb begin
    ctl.op     = pal_pkg::CELL_HOLD;
    ctl.word   = in_word_in;
    at         = pos_wide[AW-1:0];
    fill_nxt   = fill_r;
    status_nxt = pal_pkg::ST_OK;
    if (accept) begin
      case (in_kind)
        pal_pkg::KIND_APPEND: begin
          if (full) begin
            status_nxt = pal_pkg::ST_FULL;
          end else begin
            ctl.op   = pal_pkg::CELL_APPEND;
            at       = fill_r[AW-1:0];
            fill_nxt = fill_r + FW'(1);
          end
        end
        pal_pkg::KIND_INSERT: begin
          if (full) begin
            status_nxt = pal_pkg::ST_FULL;
          end else if (!pos_ok) begin
            status_nxt = pal_pkg::ST_POS;
          end else begin
            ctl.op   = pal_pkg::CELL_INSERT;
            fill_nxt = fill_r + FW'(1);
          end
        end
        pal_pkg::KIND_ERASE: begin
          if (!pos_ok) begin
            status_nxt = pal_pkg::ST_POS;
          end else begin
            ctl.op   = pal_pkg::CELL_ERASE;
            fill_nxt = fill_dec;
          end
        end
        pal_pkg::KIND_READ: begin
          if (!pos_ok) status_nxt = pal_pkg::ST_POS;
          else ctl.op = pal_pkg::CELL_READ;
        end
        default: status_nxt = pal_pkg::ST_OK;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [pal_pkg::WORD_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_head
      assign prev_w = '0;
    end else begin : g_body
      assign prev_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_w = cell_word[g];
    end else begin : g_mid
      assign next_w = cell_word[g+1];
    end
    pal_cell #(.AW(AW), .IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .at        (at),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (cell_word[g]),
      .hit_word  (cell_hit[g])
    );
  end

  always_comb begin
    gathered = '0;
    for (int k = 0; k < DEPTH; k++) begin
      gathered = gathered | cell_hit[k];
    end
  end

  assign fill_ext = {{CW{1'b0}}, fill_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    word_out_r <= gathered;
    count_r    <= fill_ext[CW-1:0];
    is_empty_r <= (fill_nxt == '0);
    status_r   <= status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = word_out_r;
  assign out_count    = count_r;
  assign out_is_empty = is_empty_r;
  assign out_status   = status_r;

  a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("beat without result");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("length past store depth");

  a_fail_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pal_pkg::ST_OK |-> fill_r == $past(fill_r))
    else $error("failed operation changed length");

  a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (fill_r == '0))
    else $error("empty flag disagrees with length");

endmodule

@@ tb/sv/tb_positional_array_list.sv @@
module tb_positional_array_list;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int DEPTH      = 128;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 1700;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic              typed;
    list_result_t      res;
  } dir_row_t;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind = KIND_APPEND;
  logic [POS_W-1:0]    in_position = '0;
  logic [WORD_W-1:0]   in_word_in = '0;
  logic                out_valid;
  logic [WORD_W-1:0]   out_word_out;
  logic [COUNT_W-1:0]  out_count;
  logic                out_is_empty;
  logic [STATUS_W-1:0] out_status;

  logic [WORD_W-1:0] list_mem [0:DEPTH-1];
  int                list_len = 0;
  list_result_t      pending_results [$];
  int                mismatches = 0;
  int                cycles = 0;

  dir_row_t dir_rows [0:N_DIRECTED-1] = '{
    '{KIND_READ,   7'd0,   32'd0,         1'b1, '{32'd0,         8'd0, 1'b1, ST_POS}},
    '{KIND_ERASE,  7'd0,   32'd0,         1'b1, '{32'd0,         8'd0, 1'b1, ST_POS}},
    '{KIND_INSERT, 7'd0,   32'd5,         1'b1, '{32'd0,         8'd0, 1'b1, ST_POS}},
    '{KIND_APPEND, 7'd127, 32'h7FFFFFFF,  1'b1, '{32'd0,         8'd1, 1'b0, ST_OK}},
    '{KIND_APPEND, 7'd0,   32'h80000000,  1'b1, '{32'd0,         8'd2, 1'b0, ST_OK}},
    '{KIND_READ,   7'd0,   32'd0,         1'b1, '{32'h7FFFFFFF,  8'd2, 1'b0, ST_OK}},
    '{KIND_READ,   7'd1,   32'd0,         1'b1, '{32'h80000000,  8'd2, 1'b0, ST_OK}},
    '{KIND_READ,   7'd2,   32'd0,         1'b1, '{32'd0,         8'd2, 1'b0, ST_POS}},
    '{KIND_INSERT, 7'd2,   32'd1,         1'b1, '{32'd0,         8'd2, 1'b0, ST_POS}},
    '{KIND_ERASE,  7'd127, 32'd0,         1'b1, '{32'd0,         8'd2, 1'b0, ST_POS}},
    '{KIND_INSERT, 7'd1,   32'hFFFFFFFF,  1'b0, '0},
    '{KIND_INSERT, 7'd0,   32'd0,         1'b0, '0},
    '{KIND_READ,   7'd3,   32'd0,         1'b0, '0},
    '{KIND_READ,   7'd1,   32'd0,         1'b0, '0},
    '{KIND_ERASE,  7'd3,   32'd0,         1'b0, '0},
    '{KIND_ERASE,  7'd0,   32'd0,         1'b0, '0},
    '{KIND_READ,   7'd1,   32'd0,         1'b0, '0},
    '{KIND_APPEND, 7'h55,  32'h55555555,  1'b0, '0},
    '{KIND_INSERT, 7'd0,   32'hAAAAAAAA,  1'b0, '0},
    '{KIND_READ,   7'd0,   32'd0,         1'b0, '0},
    '{KIND_ERASE,  7'd1,   32'd0,         1'b0, '0},
    '{KIND_ERASE,  7'd2,   32'd0,         1'b0, '0},
    '{KIND_ERASE,  7'd0,   32'd0,         1'b0, '0},
    '{KIND_ERASE,  7'd0,   32'd0,         1'b1, '{32'd0,         8'd0, 1'b1, ST_OK}},
    '{KIND_READ,   7'd0,   32'd0,         1'b1, '{32'd0,         8'd0, 1'b1, ST_POS}}
  };

  positional_array_list dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_word_out (out_word_out),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_status   (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [WORD_W-1:0] word);
    list_result_t r;
    int k;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = word;
          list_len++;
        end
      end
      KIND_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(pos) >= list_len) begin
          r.status = ST_POS;
        end else begin
          for (k = list_len; k > int'(pos); k--) list_mem[k] = list_mem[k-1];
          list_mem[pos] = word;
          list_len++;
        end
      end
      KIND_ERASE: begin
        if (int'(pos) >= list_len) begin
          r.status = ST_POS;
        end else begin
          for (k = int'(pos); k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      default: begin
        if (int'(pos) >= list_len) r.status = ST_POS;
        else r.word = list_mem[pos];
      end
    endcase
    r.count = list_len[COUNT_W-1:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
                                      logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  // drive at negedge, return at the negedge after the beat is taken
  task automatic send_beat(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                           logic [WORD_W-1:0] word, logic typed, list_result_t typed_res);
    list_result_t r;
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_word_in  <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_list_op(kind, pos, word);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none actual word %h count %0d status %0d",
                 $realtime, out_word_out, out_count, out_status);
      end else begin
        e = pending_results.pop_front();
        check_field("word_out", e.word, out_word_out);
        check_field("count", 32'(e.count), 32'(out_count));
        check_field("is_empty", 32'(e.empty), 32'(out_is_empty));
        check_field("status", 32'(e.status), 32'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int i;
    int n;
    int roll;
    int burst_left;
    int full_hits;
    int empty_hits;
    int mix_left;
    phase_t phase;
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0] p;
    logic [WORD_W-1:0] w;

    burst_left = 0;
    full_hits  = 0;
    empty_hits = 0;
    mix_left   = 0;
    phase      = PH_GROW;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_beat(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].word,
                dir_rows[i].typed, dir_rows[i].res);
      if ($urandom_range(3, 0) == 0) idle_cycles($urandom_range(3, 1));
    end
    drain_results();

    for (n = 0; n < N_RANDOM; n++) begin
      roll = $urandom_range(99, 0);
      case (phase)
        PH_GROW:
          k = (roll < 50) ? KIND_APPEND : (roll < 85) ? KIND_INSERT :
              (roll < 95) ? KIND_READ : KIND_ERASE;
        PH_SHRINK:
          k = (roll < 55) ? KIND_ERASE : (roll < 75) ? KIND_READ :
              (roll < 88) ? KIND_APPEND : KIND_INSERT;
        default:
          k = KIND_W'($urandom_range(3, 0));
      endcase
      if (list_len > 0 && $urandom_range(99, 0) < 85) p = POS_W'($urandom_range(list_len - 1, 0));
      else p = POS_W'($urandom_range(127, 0));
      if ($urandom_range(9, 0) == 0) begin
        case ($urandom_range(3, 0))
          0: w = 32'h00000000;
          1: w = 32'h7FFFFFFF;
          2: w = 32'h80000000;
          default: w = 32'hFFFFFFFF;
        endcase
      end else begin
        w = $urandom;
      end

      send_beat(k, p, w, 1'b0, '0);

      case (phase)
        PH_GROW: begin
          if (list_len == DEPTH) full_hits++;
          if (full_hits >= 8) begin
            full_hits = 0;
            phase = PH_SHRINK;
            drain_results();
          end
        end
        PH_SHRINK: begin
          if (list_len == 0) empty_hits++;
          if (empty_hits >= 5) begin
            empty_hits = 0;
            mix_left = 150;
            phase = PH_MIX;
            drain_results();
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) phase = PH_GROW;
        end
      endcase

      if (burst_left > 0) begin
        burst_left--;
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 5) burst_left = $urandom_range(60, 20);
        else if (roll < 60) ;
        else if (roll < 90) idle_cycles($urandom_range(3, 1));
        else if (roll < 98) idle_cycles($urandom_range(12, 4));
        else idle_cycles($urandom_range(60, 20));
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/pal_pkg.sv
src/pal_cell.sv
src/positional_array_list.sv
tb/sv/tb_positional_array_list.sv
